// File: hw/rtl/chunk_ring_byte_segmenter_macros.svh
// assertion macros for the chunk ring segmenter
`ifndef CHUNK_RING_BYTE_SEGMENTER_MACROS_SVH
`define CHUNK_RING_BYTE_SEGMENTER_MACROS_SVH

`ifndef ASSERT_OFF
`define CRBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRBS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CRBS_ASSERT(lbl, prop, msg)
`define CRBS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: hw/rtl/crbs_pkg.sv
`timescale 1ns / 1ps

package crbs_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int CAP_W     = 16;
    localparam int AMT_W     = 20;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 5;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 2;
    localparam int ACC_W     = 22;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd8192;

    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POPW    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BUSY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INSUF  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADCOM = 2'd3;

    localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PARTIAL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WHOLE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE   = 4'd0;
    localparam op_t OP_LOAD   = 4'd1;
    localparam op_t OP_RESV   = 4'd2;
    localparam op_t OP_COMMIT = 4'd3;
    localparam op_t OP_SUM    = 4'd4;
    localparam op_t OP_WALK   = 4'd5;
    localparam op_t OP_POPW   = 4'd6;
    localparam op_t OP_FLUSH  = 4'd7;
    localparam op_t OP_EMPTY  = 4'd8;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/chunk_ring_byte_segmenter.sv
`timescale 1ns / 1ps

// Ring of RING_DEPTH byte chunks with reserve, commit, pop, pop-whole and flush
// commands; each accepted item yields one or more output words, the final one
// flagged by last. A reserve may first close the open chunk; a byte pop first
// sums the closed chunks one per cycle, ends the sum, then emits its segments
// one per cycle while the output is not stalled. Output stalls hold the block.
// cfg_ready is always high; chunk_capacity resets to 8192; the user must write
// it only while idle, which the block itself does not enforce.

module chunk_ring_byte_segmenter
    import crbs_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [MODE_W-1:0]  mode,
    input  logic [AMT_W-1:0]   amount,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   chunk_index,
    output logic [CAP_W-1:0]   byte_offset,
    output logic [CAP_W-1:0]   seg_length,
    output logic [KIND_W-1:0]  seg_kind,
    output logic               released,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    crbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .amount   (amount),
        .cmd      (cmd),
        .sts      (sts)
    );

    crbs_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .amount      (amount),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .chunk_index (chunk_index),
        .byte_offset (byte_offset),
        .seg_length  (seg_length),
        .seg_kind    (seg_kind),
        .released    (released),
        .last        (last)
    );

endmodule

// File: hw/rtl/crbs_datapath.sv
`timescale 1ns / 1ps

module crbs_datapath
    import crbs_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [AMT_W-1:0]   amount,
    input  logic               cfg_write,
    input  logic [CAP_W-1:0]   cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [IDX_W-1:0]   chunk_index,
    output logic [CAP_W-1:0]   byte_offset,
    output logic [CAP_W-1:0]   seg_length,
    output logic [KIND_W-1:0]  seg_kind,
    output logic               released,
    output logic               last
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [CAP_W-1:0]      cap_reg;
    logic [RING_DEPTH-1:0] busy_reg, busy_next;
    logic [CAP_W-1:0]      fill_mem [RING_DEPTH];
    logic [PW-1:0]         fp_reg, fp_next;
    logic [CAP_W-1:0]      bic_reg, bic_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [CW-1:0]         qc_reg, qc_next;
    logic [PW-1:0]         pc_reg, pc_next;
    logic [CAP_W-1:0]      pl_reg, pl_next;
    logic [CAP_W-1:0]      pf_reg, pf_next;
    logic [CAP_W-1:0]      lr_reg, lr_next;
    logic [AMT_W-1:0]      amt_reg, amt_next;
    logic [AMT_W-1:0]      need_reg, need_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [PW-1:0]         cur_reg, cur_next;
    logic [CW-1:0]         j_reg, j_next;
    logic                  left0_reg, left0_next;
    logic                  iter_reg, iter_next;
    logic                  valid_reg, valid_next;

    logic [STAT_W-1:0]     status_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CAP_W-1:0]      off_reg;
    logic [CAP_W-1:0]      len_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic                  rel_reg;
    logic                  last_reg;

    logic                  emit;
    logic [STAT_W-1:0]     e_status;
    logic [PW-1:0]         e_idx;
    logic [CAP_W-1:0]      e_off;
    logic [CAP_W-1:0]      e_len;
    logic [KIND_W-1:0]     e_kind;
    logic                  e_rel;
    logic                  e_last;
    logic                  done;

    logic                  fill_we;
    logic [CAP_W-1:0]      fill_wd;
    logic [CAP_W-1:0]      rd_fill_reg;
    logic [CAP_W-1:0]      room;
    logic [CAP_W-1:0]      want;
    logic [CAP_W-1:0]      bic_sum;

    assign room    = (bic_reg >= cap_reg) ? '0 : cap_reg - bic_reg;
    assign want    = (amt_reg > AMT_W'(cap_reg)) ? cap_reg : amt_reg[CAP_W-1:0];
    assign bic_sum = bic_reg + amt_reg[CAP_W-1:0];

    always_comb
    begin
        busy_next  = busy_reg;
        fp_next    = fp_reg;
        bic_next   = bic_reg;
        head_next  = head_reg;
        qc_next    = qc_reg;
        pc_next    = pc_reg;
        pl_next    = pl_reg;
        pf_next    = pf_reg;
        lr_next    = lr_reg;
        amt_next   = amt_reg;
        need_next  = need_reg;
        acc_next   = acc_reg;
        cur_next   = cur_reg;
        j_next     = j_reg;
        left0_next = left0_reg;
        iter_next  = iter_reg;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_idx      = '0;
        e_off      = '0;
        e_len      = '0;
        e_kind     = KIND_NONE;
        e_rel      = 1'b0;
        e_last     = 1'b1;
        done       = 1'b0;
        fill_we    = 1'b0;
        fill_wd    = bic_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                amt_next   = amount;
                need_next  = amount - AMT_W'(pl_reg);
                acc_next   = ACC_W'(pl_reg);
                cur_next   = head_reg;
                j_next     = '0;
                left0_next = (pl_reg != '0);
                iter_next  = 1'b0;
            end
            OP_RESV:
            begin
                lr_next = want;
                if (busy_reg[fp_reg])
                begin
                    emit     = 1'b1;
                    e_status = ST_BUSY;
                    e_idx    = fp_reg;
                    e_off    = bic_reg;
                    done     = 1'b1;
                end
                else if (room >= want)
                begin
                    emit  = 1'b1;
                    e_idx = fp_reg;
                    e_off = bic_reg;
                    done  = 1'b1;
                end
                else
                begin
                    fill_we           = 1'b1;
                    fill_wd           = bic_reg;
                    busy_next[fp_reg] = 1'b1;
                    qc_next           = qc_reg + 1'b1;
                    fp_next           = ptr_inc(fp_reg);
                    bic_next          = '0;
                    iter_next         = 1'b1;
                    if (iter_reg)
                    begin
                        emit  = 1'b1;
                        e_idx = ptr_inc(fp_reg);
                        done  = 1'b1;
                    end
                end
            end
            OP_COMMIT:
            begin
                emit  = 1'b1;
                e_idx = fp_reg;
                e_off = bic_reg;
                done  = 1'b1;
                if (busy_reg[fp_reg] || amt_reg > AMT_W'(lr_reg) || amt_reg > AMT_W'(room))
                begin
                    e_status = ST_BADCOM;
                end
                else if (amt_reg[CAP_W-1:0] == room)
                begin
                    fill_we           = 1'b1;
                    fill_wd           = bic_sum;
                    busy_next[fp_reg] = 1'b1;
                    qc_next           = qc_reg + 1'b1;
                    fp_next           = ptr_inc(fp_reg);
                    bic_next          = '0;
                end
                else
                begin
                    bic_next = bic_sum;
                end
            end
            OP_SUM:
            begin
                if (j_reg == qc_reg)
                begin
                    done     = 1'b1;
                    cur_next = head_reg;
                    j_next   = '0;
                end
                else
                begin
                    acc_next = acc_reg + ACC_W'(rd_fill_reg);
                    cur_next = ptr_inc(cur_reg);
                    j_next   = j_reg + 1'b1;
                end
            end
            OP_WALK:
            begin
                emit = 1'b1;
                if (acc_reg < ACC_W'(amt_reg))
                begin
                    e_status = ST_INSUF;
                    done     = 1'b1;
                end
                else if (pl_reg != '0)
                begin
                    e_idx = pc_reg;
                    e_off = pf_reg - pl_reg;
                    e_rel = 1'b1;
                    if (AMT_W'(pl_reg) >= amt_reg)
                    begin
                        e_len   = amt_reg[CAP_W-1:0];
                        e_kind  = KIND_WHOLE;
                        e_rel   = (pl_reg == amt_reg[CAP_W-1:0]);
                        pl_next = pl_reg - amt_reg[CAP_W-1:0];
                        if (e_rel)
                        begin
                            busy_next[pc_reg] = 1'b0;
                        end
                        done = 1'b1;
                    end
                    else
                    begin
                        e_len             = pl_reg;
                        e_kind            = KIND_START;
                        e_last            = 1'b0;
                        busy_next[pc_reg] = 1'b0;
                        pl_next           = '0;
                    end
                end
                else
                begin
                    e_idx = cur_reg;
                    if (AMT_W'(rd_fill_reg) >= need_reg)
                    begin
                        e_kind    = (left0_reg || j_reg != '0) ? KIND_END : KIND_WHOLE;
                        head_next = ptr_inc(cur_reg);
                        qc_next   = qc_reg - (j_reg + 1'b1);
                        done      = 1'b1;
                        if (rd_fill_reg == need_reg[CAP_W-1:0])
                        begin
                            e_len              = rd_fill_reg;
                            e_rel              = 1'b1;
                            busy_next[cur_reg] = 1'b0;
                            pl_next            = '0;
                        end
                        else
                        begin
                            e_len   = need_reg[CAP_W-1:0];
                            pc_next = cur_reg;
                            pf_next = rd_fill_reg;
                            pl_next = rd_fill_reg - need_reg[CAP_W-1:0];
                        end
                    end
                    else
                    begin
                        e_len              = rd_fill_reg;
                        e_kind             = (!left0_reg && j_reg == '0) ? KIND_START
                                                                         : KIND_PARTIAL;
                        e_rel              = 1'b1;
                        e_last             = 1'b0;
                        busy_next[cur_reg] = 1'b0;
                        need_next          = need_reg - AMT_W'(rd_fill_reg);
                        cur_next           = ptr_inc(cur_reg);
                        j_next             = j_reg + 1'b1;
                    end
                end
            end
            OP_POPW:
            begin
                emit = 1'b1;
                done = 1'b1;
                if (qc_reg == '0)
                begin
                    e_status = ST_INSUF;
                end
                else
                begin
                    e_idx               = head_reg;
                    e_len               = rd_fill_reg;
                    e_kind              = KIND_WHOLE;
                    e_rel               = 1'b1;
                    busy_next[head_reg] = 1'b0;
                    head_next           = ptr_inc(head_reg);
                    qc_next             = qc_reg - 1'b1;
                end
            end
            OP_FLUSH:
            begin
                emit      = 1'b1;
                done      = 1'b1;
                busy_next = '0;
                qc_next   = '0;
                head_next = '0;
                bic_next  = '0;
                fp_next   = '0;
                lr_next   = '0;
                pl_next   = '0;
            end
            OP_EMPTY:
            begin
                emit = 1'b1;
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign valid_next   = emit ? 1'b1 : (valid_reg && out_stall);
    assign sts.done     = done;
    assign sts.out_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            busy_reg  <= '0;
            fp_reg    <= '0;
            bic_reg   <= '0;
            head_reg  <= '0;
            qc_reg    <= '0;
            pc_reg    <= '0;
            pl_reg    <= '0;
            pf_reg    <= '0;
            lr_reg    <= '0;
            amt_reg   <= '0;
            need_reg  <= '0;
            acc_reg   <= '0;
            cur_reg   <= '0;
            j_reg     <= '0;
            left0_reg <= 1'b0;
            iter_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
            busy_reg  <= busy_next;
            fp_reg    <= fp_next;
            bic_reg   <= bic_next;
            head_reg  <= head_next;
            qc_reg    <= qc_next;
            pc_reg    <= pc_next;
            pl_reg    <= pl_next;
            pf_reg    <= pf_next;
            lr_reg    <= lr_next;
            amt_reg   <= amt_next;
            need_reg  <= need_next;
            acc_reg   <= acc_next;
            cur_reg   <= cur_next;
            j_reg     <= j_next;
            left0_reg <= left0_next;
            iter_reg  <= iter_next;
            valid_reg <= valid_next;
        end
    end

    // read port is addressed by the next walk pointer, so rd_fill_reg holds the fill at cur_reg
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fp_reg] <= fill_wd;
        end
        rd_fill_reg <= fill_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= e_status;
            idx_reg    <= IDX_W'(e_idx);
            off_reg    <= e_off;
            len_reg    <= e_len;
            kind_reg   <= e_kind;
            rel_reg    <= e_rel;
            last_reg   <= e_last;
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign chunk_index = idx_reg;
    assign byte_offset = off_reg;
    assign seg_length  = len_reg;
    assign seg_kind    = kind_reg;
    assign released    = rel_reg;
    assign last        = last_reg;

endmodule

// File: hw/rtl/crbs_ctrl.sv
`timescale 1ns / 1ps
`include "chunk_ring_byte_segmenter_macros.svh"

module crbs_ctrl
    import crbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [AMT_W-1:0]  amount,
    output cmd_t              cmd,
    input  sts_t              sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RESV = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_ONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    op_t        one_op_reg, one_op_next;

    always_comb
    begin
        state_next  = state_reg;
        one_op_next = one_op_reg;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ONE;
                    case (mode)
                        MODE_RESERVE: state_next  = S_RESV;
                        MODE_COMMIT:  one_op_next = OP_COMMIT;
                        MODE_POP:
                        begin
                            if (amount == '0)
                            begin
                                one_op_next = OP_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SUM;
                            end
                        end
                        MODE_POPW:    one_op_next = OP_POPW;
                        MODE_FLUSH:   one_op_next = OP_FLUSH;
                        default:      one_op_next = OP_EMPTY;
                    endcase
                end
            end
            S_RESV:
            begin
                if (sts.out_free)
                begin
                    cmd.op = OP_RESV;
                    if (sts.done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                if (sts.done)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.out_free)
                begin
                    cmd.op = OP_WALK;
                    if (sts.done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = one_op_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            one_op_reg <= OP_EMPTY;
        end
        else
        begin
            state_reg  <= state_next;
            one_op_reg <= one_op_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `CRBS_ASSERT_NEXT(a_accept_holds, in_valid && !in_stall, in_stall, "no busy after accept")
    `CRBS_ASSERT(a_emit_when_free, cmd.op == OP_NONE || cmd.op == OP_LOAD || cmd.op == OP_SUM || sts.out_free, "word emitted over pending output")
    `CRBS_ASSERT_NEXT(a_done_to_idle, (state_reg == S_WALK || state_reg == S_RESV) && cmd.op != OP_NONE && sts.done, !in_stall, "not idle after last word")

endmodule
